FILE: hw/rtl/es2c_pkg.sv
// Shared types, constants and helper functions for the epoch seconds to calendar block.
package es2c_pkg;

	// Field widths.
	localparam int SECONDS_W   = 32;
	localparam int BASE_YEAR_W = 12;
	localparam int YEAR_W      = 13;
	localparam int MONTH_W     = 4;
	localparam int DAY_W       = 5;
	localparam int HOUR_W      = 5;
	localparam int MINUTE_W    = 6;
	localparam int SECOND_W    = 6;

	// Datapath widths.
	localparam int DAYS_W = 16;    // whole days in a 32-bit second count
	localparam int REM_W  = 17;    // remainder of a division by one day in seconds
	localparam int YMOD_W = 7;     // year within its century
	localparam int YLEN_W = 9;

	// Constant divisors of the shared reciprocal unit.
	localparam logic [REM_W-1:0] SECS_PER_DAY  = REM_W'(86400);
	localparam logic [REM_W-1:0] SECS_PER_HOUR = REM_W'(3600);
	localparam logic [REM_W-1:0] SECS_PER_MIN  = REM_W'(60);
	localparam logic [REM_W-1:0] YEARS_PER_CEN = REM_W'(100);

	// A quotient is ((x >> PRE) * MAG) >> POST. Each magic number is the rounded-up
	// reciprocal of the odd part of its divisor (of the whole divisor for the century
	// step, with no pre-shift); each is exact over the whole dividend range of its step.
	localparam int RECIP_X_W = 25;
	localparam int RECIP_M_W = 26;
	localparam int MUL_P_W   = RECIP_X_W + RECIP_M_W;

	localparam int                   DAY_PRE_SH   = 7;
	localparam logic [RECIP_M_W-1:0] DAY_MAG      = RECIP_M_W'(50903317);
	localparam int                   DAY_POST_SH  = 35;
	localparam int                   HOUR_PRE_SH  = 4;
	localparam logic [RECIP_M_W-1:0] HOUR_MAG     = RECIP_M_W'(9321);
	localparam int                   HOUR_POST_SH = 21;
	localparam int                   MIN_PRE_SH   = 2;
	localparam logic [RECIP_M_W-1:0] MIN_MAG      = RECIP_M_W'(1093);
	localparam int                   MIN_POST_SH  = 14;
	localparam logic [RECIP_M_W-1:0] CEN_MAG      = RECIP_M_W'(5243);
	localparam int                   CEN_POST_SH  = 19;

	// Each division has a quotient step and a remainder step.
	localparam int DIV_STEPS = 2;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [YLEN_W-1:0]  DAYS_LEAP_YEAR   = YLEN_W'(366);
	localparam logic [YLEN_W-1:0]  DAYS_COMMON_YEAR = YLEN_W'(365);
	localparam logic [YMOD_W-1:0]  LAST_YEAR_OF_CEN = YMOD_W'(99);
	localparam logic [MONTH_W-1:0] MON_FEB          = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MON_APR          = MONTH_W'(3);
	localparam logic [MONTH_W-1:0] MON_JUN          = MONTH_W'(5);
	localparam logic [MONTH_W-1:0] MON_SEP          = MONTH_W'(8);
	localparam logic [MONTH_W-1:0] MON_NOV          = MONTH_W'(10);
	localparam logic [MONTH_W-1:0] MON_DEC          = MONTH_W'(11);
	localparam logic [DAY_W-1:0]   FEB_DAYS_COMMON  = DAY_W'(28);
	localparam logic [DAY_W-1:0]   FEB_DAYS_LEAP    = DAY_W'(29);
	localparam logic [DAY_W-1:0]   SHORT_MON_DAYS   = DAY_W'(30);
	localparam logic [DAY_W-1:0]   LONG_MON_DAYS    = DAY_W'(31);

	localparam logic [BASE_YEAR_W-1:0] BASE_YEAR_RESET = BASE_YEAR_W'(2025);

	// Which division the shared unit is running.
	typedef enum logic [1:0] {
		PH_DAY  = 2'd0,
		PH_HOUR = 2'd1,
		PH_MIN  = 2'd2,
		PH_CEN  = 2'd3
	} es2c_phase_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic        start;
		logic        div_step;
		logic        div_last;
		es2c_phase_t phase;
		logic        year_step;
		logic        month_step;
		logic        out_load;
	} es2c_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic year_done;
		logic month_done;
	} es2c_sts_t;

	// Length of a month counted from zero for January.
	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mon,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (mon)
			MON_FEB: len = leap ? FEB_DAYS_LEAP : FEB_DAYS_COMMON;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: len = SHORT_MON_DAYS;
			default: len = LONG_MON_DAYS;
		endcase
		return len;
	endfunction

endpackage

FILE: hw/rtl/es2c_if.sv
// Valid/ready channel interfaces for the request and result sides.
interface es2c_req_if;
	logic                           valid;
	logic                           ready;
	logic [es2c_pkg::SECONDS_W-1:0] seconds_count;

	modport source (output valid, output seconds_count, input ready);
	modport sink (input valid, input seconds_count, output ready);
endinterface

interface es2c_res_if;
	logic                          valid;
	logic                          ready;
	logic [es2c_pkg::YEAR_W-1:0]   year_out;
	logic [es2c_pkg::MONTH_W-1:0]  month_out;
	logic [es2c_pkg::DAY_W-1:0]    day_out;
	logic [es2c_pkg::HOUR_W-1:0]   hour_out;
	logic [es2c_pkg::MINUTE_W-1:0] minute_out;
	logic [es2c_pkg::SECOND_W-1:0] second_out;

	modport source (output valid, output year_out, output month_out, output day_out,
		output hour_out, output minute_out, output second_out, input ready);
	modport sink (input valid, input year_out, input month_out, input day_out,
		input hour_out, input minute_out, input second_out, output ready);
endinterface

FILE: hw/rtl/es2c_ctrl.sv
// Sequencing state machine of the epoch seconds to calendar block.
module es2c_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  es2c_pkg::es2c_sts_t sts,
	output es2c_pkg::es2c_cmd_t cmd
);
	import es2c_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_DAY   = 8'b0000_0010,
		ST_HOUR  = 8'b0000_0100,
		ST_MIN   = 8'b0000_1000,
		ST_CEN   = 8'b0001_0000,
		ST_YEAR  = 8'b0010_0000,
		ST_MONTH = 8'b0100_0000,
		ST_WB    = 8'b1000_0000
	} state_t;

	state_t           state_q;
	state_t           state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             cnt_zero;

	assign cnt_zero  = (cnt_q == '0);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.phase = PH_DAY;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_nxt = ST_DAY;
				end
			end
			ST_DAY: begin
				cmd.div_step = 1'b1;
				cmd.phase    = PH_DAY;
				if (cnt_zero) begin
					cmd.div_last = 1'b1;
					state_nxt    = ST_HOUR;
				end
			end
			ST_HOUR: begin
				cmd.div_step = 1'b1;
				cmd.phase    = PH_HOUR;
				if (cnt_zero) begin
					cmd.div_last = 1'b1;
					state_nxt    = ST_MIN;
				end
			end
			ST_MIN: begin
				cmd.div_step = 1'b1;
				cmd.phase    = PH_MIN;
				if (cnt_zero) begin
					cmd.div_last = 1'b1;
					state_nxt    = ST_CEN;
				end
			end
			ST_CEN: begin
				cmd.div_step = 1'b1;
				cmd.phase    = PH_CEN;
				if (cnt_zero) begin
					cmd.div_last = 1'b1;
					state_nxt    = ST_YEAR;
				end
			end
			ST_YEAR: begin
				cmd.year_step = 1'b1;
				if (sts.year_done) begin
					state_nxt = ST_MONTH;
				end
			end
			ST_MONTH: begin
				cmd.month_step = 1'b1;
				if (sts.month_done) begin
					state_nxt = ST_WB;
				end
			end
			ST_WB: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.start || cmd.div_last) begin
				cnt_q <= CNT_W'(DIV_STEPS - 1);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/es2c_dp.sv
// Datapath: shared reciprocal divider, year and month reduction, result register.
module es2c_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [es2c_pkg::BASE_YEAR_W-1:0]    cfg_wdata,
	input  logic [es2c_pkg::SECONDS_W-1:0]      seconds_count,
	input  es2c_pkg::es2c_cmd_t                 cmd,
	output es2c_pkg::es2c_sts_t                 sts,
	output logic [es2c_pkg::YEAR_W-1:0]         year_out,
	output logic [es2c_pkg::MONTH_W-1:0]        month_out,
	output logic [es2c_pkg::DAY_W-1:0]          day_out,
	output logic [es2c_pkg::HOUR_W-1:0]         hour_out,
	output logic [es2c_pkg::MINUTE_W-1:0]       minute_out,
	output logic [es2c_pkg::SECOND_W-1:0]       second_out
);
	import es2c_pkg::*;

	logic [BASE_YEAR_W-1:0] base_year_q;

	// Reciprocal divider: the first step of a division registers the
	// quotient, the second forms the remainder from it.
	logic [SECONDS_W-1:0] num_q;
	logic [DAYS_W-1:0]    quo_q;
	logic [RECIP_X_W-1:0] mul_x;
	logic [RECIP_M_W-1:0] mul_m;
	logic [MUL_P_W-1:0]   mul_p;
	logic [DAYS_W-1:0]    quo_est;
	logic [REM_W-1:0]     divisor;
	logic [SECONDS_W-1:0] rem_full;
	logic [REM_W-1:0]     rem_nxt;

	logic [DAYS_W-1:0]   days_q;
	logic [YEAR_W-1:0]   yr_q;
	logic [YMOD_W-1:0]   ymod_q;
	logic [1:0]          cen_q;
	logic [MONTH_W-1:0]  mon_q;
	logic [HOUR_W-1:0]   hour_q;
	logic [MINUTE_W-1:0] minute_q;
	logic [SECOND_W-1:0] second_q;

	logic                leap;
	logic [YLEN_W-1:0]   ylen;
	logic [DAY_W-1:0]    mlen;

	always_comb begin
		case (cmd.phase)
			PH_DAY: begin
				mul_x   = RECIP_X_W'(num_q >> DAY_PRE_SH);
				mul_m   = DAY_MAG;
				divisor = SECS_PER_DAY;
			end
			PH_HOUR: begin
				mul_x   = RECIP_X_W'(num_q >> HOUR_PRE_SH);
				mul_m   = HOUR_MAG;
				divisor = SECS_PER_HOUR;
			end
			PH_MIN: begin
				mul_x   = RECIP_X_W'(num_q >> MIN_PRE_SH);
				mul_m   = MIN_MAG;
				divisor = SECS_PER_MIN;
			end
			default: begin
				mul_x   = RECIP_X_W'(num_q);
				mul_m   = CEN_MAG;
				divisor = YEARS_PER_CEN;
			end
		endcase
	end

	assign mul_p = MUL_P_W'(mul_x) * MUL_P_W'(mul_m);

	always_comb begin
		case (cmd.phase)
			PH_DAY:  quo_est = DAYS_W'(mul_p >> DAY_POST_SH);
			PH_HOUR: quo_est = DAYS_W'(mul_p >> HOUR_POST_SH);
			PH_MIN:  quo_est = DAYS_W'(mul_p >> MIN_POST_SH);
			default: quo_est = DAYS_W'(mul_p >> CEN_POST_SH);
		endcase
	end

	assign rem_full = num_q - SECONDS_W'(quo_q) * SECONDS_W'(divisor);
	assign rem_nxt  = rem_full[REM_W-1:0];

	// Leap rule from the year within its century and the century modulo four.
	assign leap = ((ymod_q[1:0] == 2'd0) && (ymod_q != '0)) ||
		((ymod_q == '0) && (cen_q == 2'd0));
	assign ylen = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
	assign mlen = month_days(mon_q, leap);

	assign sts.year_done  = (days_q < DAYS_W'(ylen));
	assign sts.month_done = (mon_q == MON_DEC) || (days_q < DAYS_W'(mlen));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_year_q <= BASE_YEAR_RESET;
		end else if (cfg_we) begin
			base_year_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			num_q <= seconds_count;
		end else if (cmd.div_last) begin
			// Store the results; pass the remainder (after minutes, the base year) to the next division.
			case (cmd.phase)
				PH_DAY: begin
					days_q <= quo_q;
					num_q  <= SECONDS_W'(rem_nxt);
				end
				PH_HOUR: begin
					hour_q <= quo_q[HOUR_W-1:0];
					num_q  <= SECONDS_W'(rem_nxt);
				end
				PH_MIN: begin
					minute_q <= quo_q[MINUTE_W-1:0];
					second_q <= rem_nxt[SECOND_W-1:0];
					num_q    <= SECONDS_W'(base_year_q);
				end
				default: begin
					cen_q  <= quo_q[1:0];
					ymod_q <= rem_nxt[YMOD_W-1:0];
					yr_q   <= YEAR_W'(base_year_q);
					mon_q  <= '0;
				end
			endcase
		end else if (cmd.div_step) begin
			quo_q <= quo_est;
		end

		if (cmd.year_step && !sts.year_done) begin
			days_q <= days_q - DAYS_W'(ylen);
			yr_q   <= yr_q + YEAR_W'(1);
			if (ymod_q == LAST_YEAR_OF_CEN) begin
				ymod_q <= '0;
				cen_q  <= cen_q + 2'd1;
			end else begin
				ymod_q <= ymod_q + YMOD_W'(1);
			end
		end

		if (cmd.month_step && !sts.month_done) begin
			days_q <= days_q - DAYS_W'(mlen);
			mon_q  <= mon_q + MONTH_W'(1);
		end

		if (cmd.out_load) begin
			year_out   <= yr_q;
			month_out  <= mon_q + MONTH_W'(1);
			day_out    <= days_q[DAY_W-1:0] + DAY_W'(1);
			hour_out   <= hour_q;
			minute_out <= minute_q;
			second_out <= second_q;
		end
	end

endmodule

FILE: hw/rtl/epoch_seconds_to_calendar.sv
// Top level of the epoch seconds to calendar converter.
// The time from request to result grows with Y (0 to 136), the number of
// whole years passed, and M (0 to 11), the number of whole months.
// Throughput: one request at a time, each passing through the four
// reciprocal divisions and the one-year-per-cycle loop.
// Reset: arst_n clears the controller and the result valid flag at once and
// sets base_year back to 2025; the result payload is not reset.
module epoch_seconds_to_calendar (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [es2c_pkg::BASE_YEAR_W-1:0] cfg_wdata,
	es2c_req_if.sink                         req,
	es2c_res_if.source                       res
);
	import es2c_pkg::*;

	// The controller steps through four divisions by constants on one shared
	// reciprocal unit. Each has two steps: a multiply by the reciprocal
	// gives the quotient, then the remainder is formed from that quotient.
	// A request of seconds is split into days (by 86400), hour (by 3600) and
	// minute and second (by 60). The base year is then split by 100 so that
	// the leap rule runs on a year-of-century counter and a century-modulo-four
	// counter instead of on dividers.
	// After that, one year is taken off per cycle until fewer days remain than
	// the current year holds, and then one month per cycle up to December.
	// The result sits in an output register, so a new request is taken while
	// an earlier result still waits on the result side.

	es2c_cmd_t cmd;
	es2c_sts_t sts;

	es2c_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	es2c_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.seconds_count (req.seconds_count),
		.cmd           (cmd),
		.sts           (sts),
		.year_out      (res.year_out),
		.month_out     (res.month_out),
		.day_out       (res.day_out),
		.hour_out      (res.hour_out),
		.minute_out    (res.minute_out),
		.second_out    (res.second_out)
	);

endmodule

FILE: hw/rtl/es2c_checker.sv
// Port-level assertions for the epoch seconds to calendar block, with its bind.
module es2c_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_ready,
	input logic                            res_valid,
	input logic                            res_ready,
	input logic [es2c_pkg::YEAR_W-1:0]     year_out,
	input logic [es2c_pkg::MONTH_W-1:0]    month_out,
	input logic [es2c_pkg::DAY_W-1:0]      day_out,
	input logic [es2c_pkg::HOUR_W-1:0]     hour_out,
	input logic [es2c_pkg::MINUTE_W-1:0]   minute_out,
	input logic [es2c_pkg::SECOND_W-1:0]   second_out
);
	import es2c_pkg::*;

	// A stalled result stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its date.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(year_out) && $stable(month_out) &&
		$stable(day_out))
		else $error("result payload changed while stalled");

	// The converter works on one request at a time.
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while converting");

	// Every delivered month, hour, minute and second is in calendar range, and the day is at least one.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (month_out >= MONTH_W'(1)) && (month_out <= MONTH_W'(12)) &&
		(day_out >= DAY_W'(1)) && (hour_out <= HOUR_W'(23)) &&
		(minute_out <= MINUTE_W'(59)) && (second_out <= SECOND_W'(59)))
		else $error("result out of calendar range");

endmodule

bind epoch_seconds_to_calendar es2c_checker u_es2c_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.year_out   (res.year_out),
	.month_out  (res.month_out),
	.day_out    (res.day_out),
	.hour_out   (res.hour_out),
	.minute_out (res.minute_out),
	.second_out (res.second_out)
);
